/* hw/rtl/prt_pkg.sv */
// ----------------------------------------------------------------------------
// prt_pkg: shared types and constants for the three-axis point rotator
// point structs, sine word type and the elaboration-time sine table builder
// ----------------------------------------------------------------------------
package prt_pkg;

  // one full period of the sine table and the quarter-period cosine offset
  localparam int SCALE_STEPS = 1024;
  localparam int SCALE_SHIFT = $clog2(SCALE_STEPS);
  localparam int QUARTER     = SCALE_STEPS / 4;
  localparam int TABLE_DEPTH = SCALE_STEPS + QUARTER;
  localparam int ROM_AW      = $clog2(TABLE_DEPTH);

  localparam int COORD_W = 16;
  localparam int ANGLE_W = 10;
  localparam int SINE_W  = 12;

  // configuration register indexes
  localparam logic [1:0] REG_ANGLE_X = 2'd0;
  localparam logic [1:0] REG_ANGLE_Y = 2'd1;
  localparam logic [1:0] REG_ANGLE_Z = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [SINE_W-1:0]  sine_t;
  typedef logic [ANGLE_W-1:0]        angle_t;
  typedef sine_t                     sine_rom_t [TABLE_DEPTH];

  typedef struct packed {
    coord_t in_x;
    coord_t in_y;
    coord_t in_z;
  } point_in_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    coord_t out_z;
  } point_out_t;

  // 2*pi in unsigned q60 and its splits by one and two periods
  localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
  localparam logic [63:0] SCALE_U    = 64'(SCALE_STEPS);
  localparam logic [63:0] SCALE_X2   = 64'(2 * SCALE_STEPS);
  localparam logic [63:0] TP_DIV_N   = TWO_PI_Q60 / SCALE_U;
  localparam logic [63:0] TP_MOD_N   = TWO_PI_Q60 % SCALE_U;
  localparam logic [63:0] TP_DIV_2N  = TWO_PI_Q60 / SCALE_X2;
  localparam logic [63:0] TP_MOD_2N  = TWO_PI_Q60 % SCALE_X2;

  // q60 product of two unsigned values below 2^62
  function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] al, ah, bl, bh, ll, lh, hl, hh, mid, lo, hi;
    al  = {32'b0, a[31:0]};
    ah  = a >> 32;
    bl  = {32'b0, b[31:0]};
    bh  = b >> 32;
    ll  = al * bl;
    lh  = al * bh;
    hl  = ah * bl;
    hh  = ah * bh;
    mid = (ll >> 32) + {32'b0, lh[31:0]} + {32'b0, hl[31:0]};
    lo  = {mid[31:0], ll[31:0]};
    hi  = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
    return (hi << 4) | (lo >> 60);
  endfunction

  // truncated scaled sine by taylor series, exact to the last bit
  function automatic sine_t scaled_sine(input int idx);
    logic [63:0] p, x, x2, term, sum, sh, sl, mag;
    logic        neg;
    p   = 64'(idx % SCALE_STEPS);
    neg = 1'b0;
    if (2 * p > SCALE_U) begin
      p   = SCALE_U - p;
      neg = 1'b1;
    end
    if (4 * p > SCALE_U) begin
      p = SCALE_U - 2 * p;
      x = TP_DIV_2N * p + (TP_MOD_2N * p) / SCALE_X2;
    end else begin
      x = TP_DIV_N * p + (TP_MOD_N * p) / SCALE_U;
    end
    x2   = q60_mul(x, x);
    term = x;
    sum  = x;
    for (int k = 1; k <= 13; k++) begin
      term = q60_mul(term, x2);
      case (k)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        6:       term = term / 64'd156;
        7:       term = term / 64'd210;
        8:       term = term / 64'd272;
        9:       term = term / 64'd342;
        10:      term = term / 64'd420;
        11:      term = term / 64'd506;
        12:      term = term / 64'd600;
        default: term = term / 64'd702;
      endcase
      if ((k % 2) == 1) sum = sum - term;
      else sum = sum + term;
    end
    sum = sum + (64'd1 << 20);
    sh  = sum >> 30;
    sl  = sum & 64'h3FFF_FFFF;
    mag = (sh * SCALE_U + ((sl * SCALE_U) >> 30)) >> 30;
    if (neg) mag = -mag;
    return sine_t'(mag[SINE_W-1:0]);
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int i = 0; i < TABLE_DEPTH; i++) rom[i] = scaled_sine(i);
    return rom;
  endfunction

endpackage

/* hw/rtl/prt_plane_rot.sv */
// ----------------------------------------------------------------------------
// prt_plane_rot: one plane rotation, two register stages
// multiply stage, then sum, truncating divide by the scale and 16-bit wrap
// ----------------------------------------------------------------------------
module prt_plane_rot (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_vld,
  input  prt_pkg::coord_t a,
  input  prt_pkg::coord_t b,
  input  prt_pkg::coord_t pass,
  input  prt_pkg::sine_t  sin_v,
  input  prt_pkg::sine_t  cos_v,
  output logic           rot_vld,
  output prt_pkg::coord_t rot_a,
  output prt_pkg::coord_t rot_b,
  output prt_pkg::coord_t rot_pass
);
  import prt_pkg::*;

  localparam int PROD_W = COORD_W + SINE_W;
  localparam int SUM_W  = PROD_W + 1;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  logic  mul_vld_r;
  prod_t ac_r, bs_r, as_r, bc_r;
  prod_t ac_nxt, bs_nxt, as_nxt, bc_nxt;
  coord_t pass_r;

  sum_t   sum_a, sum_b, bias_a, bias_b;
  coord_t rot_a_nxt, rot_b_nxt;

  always_comb begin
    ac_nxt = a * cos_v;
    bs_nxt = b * sin_v;
    as_nxt = a * sin_v;
    bc_nxt = b * cos_v;
  end

  // truncation toward zero: bias negative sums by scale minus one
  always_comb begin
    sum_a  = SUM_W'(ac_r) - SUM_W'(bs_r);
    sum_b  = SUM_W'(as_r) + SUM_W'(bc_r);
    bias_a = sum_a + (sum_a[SUM_W-1] ? SUM_W'(SCALE_STEPS - 1) : '0);
    bias_b = sum_b + (sum_b[SUM_W-1] ? SUM_W'(SCALE_STEPS - 1) : '0);
    rot_a_nxt = bias_a[SCALE_SHIFT+COORD_W-1:SCALE_SHIFT];
    rot_b_nxt = bias_b[SCALE_SHIFT+COORD_W-1:SCALE_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
      rot_vld   <= 1'b0;
    end else begin
      mul_vld_r <= in_vld;
      rot_vld   <= mul_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    ac_r     <= ac_nxt;
    bs_r     <= bs_nxt;
    as_r     <= as_nxt;
    bc_r     <= bc_nxt;
    pass_r   <= pass;
    rot_a    <= rot_a_nxt;
    rot_b    <= rot_b_nxt;
    rot_pass <= pass_r;
  end

endmodule

/* hw/rtl/point_rotate_three_axis.sv */
// ----------------------------------------------------------------------------
// point_rotate_three_axis: fixed-point 3d euler rotation of a point stream
// throughput: one point per cycle while busy is low
// three plane rotations of two stages each
// after reset or any angle write, busy is high while the six sin/cos words
// are fetched from the sine rom, one word per rom read
// reset clears all angles to 0; the receiver cannot stall the result strobe
// ----------------------------------------------------------------------------
module point_rotate_three_axis (
  input  logic                clk,
  input  logic                rst_n,
  // point input channel
  input  logic                start,
  output logic                busy,
  input  prt_pkg::point_in_t  in_data,
  // result channel
  output logic                out_valid,
  output prt_pkg::point_out_t out_data,
  // apb register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import prt_pkg::*;

  // sine rom, one period plus a quarter so cosine is a plain offset read
  localparam sine_rom_t SINE_ROM = build_sine_rom();

  localparam int          COEF_N   = 6;
  localparam logic [2:0]  LOAD_LEN = 3'(COEF_N);

  typedef enum logic {ST_LOAD, ST_IDLE} load_state_t;

  // --------------------------------------------------------------------------
  // register port
  // --------------------------------------------------------------------------
  angle_t      angle_x_r, angle_y_r, angle_z_r;
  logic [1:0]  reg_idx;
  logic        apb_wr;
  logic        reg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign apb_wr  = psel && penable && pwrite;
  // a write to an unmapped slot is ignored and does not refetch
  assign reg_wr  = apb_wr && (reg_idx inside {REG_ANGLE_X, REG_ANGLE_Y, REG_ANGLE_Z});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_x_r <= '0;
      angle_y_r <= '0;
      angle_z_r <= '0;
    end else if (apb_wr) begin
      case (reg_idx)
        REG_ANGLE_X: angle_x_r <= pwdata[ANGLE_W-1:0];
        REG_ANGLE_Y: angle_y_r <= pwdata[ANGLE_W-1:0];
        REG_ANGLE_Z: angle_z_r <= pwdata[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ANGLE_X: prdata = 32'(angle_x_r);
      REG_ANGLE_Y: prdata = 32'(angle_y_r);
      REG_ANGLE_Z: prdata = 32'(angle_z_r);
      default:     prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // coefficient fetch: sin/cos of each angle read one word per cycle
  // order: sin x, cos x, sin y, cos y, sin z, cos z
  // --------------------------------------------------------------------------
  load_state_t      state_r;
  logic [2:0]       rd_cnt_r;
  logic             rom_vld_r;
  logic [2:0]       rom_sel_r;
  sine_t            rom_q_r;
  logic [ROM_AW-1:0] rom_addr;
  angle_t           angle_sel;
  sine_t            coef_r [COEF_N];

  always_comb begin
    case (rd_cnt_r[2:1])
      2'd0:    angle_sel = angle_x_r;
      2'd1:    angle_sel = angle_y_r;
      default: angle_sel = angle_z_r;
    endcase
    // odd slots read the cosine a quarter period on
    rom_addr = ROM_AW'(angle_sel) + (rd_cnt_r[0] ? ROM_AW'(QUARTER) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      rd_cnt_r  <= '0;
      rom_vld_r <= 1'b0;
      rom_sel_r <= '0;
    end else if (reg_wr) begin
      // new angle: refetch all six words
      state_r   <= ST_LOAD;
      rd_cnt_r  <= '0;
      rom_vld_r <= 1'b0;
    end else begin
      case (state_r)
        ST_LOAD: begin
          if (rd_cnt_r != LOAD_LEN) begin
            rom_vld_r <= 1'b1;
            rom_sel_r <= rd_cnt_r;
            rd_cnt_r  <= rd_cnt_r + 3'd1;
          end else begin
            // last word lands on this edge
            rom_vld_r <= 1'b0;
            state_r   <= ST_IDLE;
          end
        end
        default: rom_vld_r <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rom_q_r <= SINE_ROM[rom_addr];
    if (rom_vld_r) coef_r[rom_sel_r] <= rom_q_r;
  end

  assign busy = (state_r == ST_LOAD);

  // --------------------------------------------------------------------------
  // rotation pipeline: x-z by angle x, y-z by angle y, x-y by angle z
  // --------------------------------------------------------------------------
  logic   in_take;
  logic   r1_vld, r2_vld, r3_vld;
  coord_t r1_x, r1_z, r1_y;
  coord_t r2_y, r2_z, r2_x;
  coord_t r3_x, r3_y, r3_z;

  assign in_take = start && !busy;

  prt_plane_rot u_rot_xz (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_take),
    .a        (in_data.in_x),
    .b        (in_data.in_z),
    .pass     (in_data.in_y),
    .sin_v    (coef_r[0]),
    .cos_v    (coef_r[1]),
    .rot_vld  (r1_vld),
    .rot_a    (r1_x),
    .rot_b    (r1_z),
    .rot_pass (r1_y)
  );

  prt_plane_rot u_rot_yz (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (r1_vld),
    .a        (r1_y),
    .b        (r1_z),
    .pass     (r1_x),
    .sin_v    (coef_r[2]),
    .cos_v    (coef_r[3]),
    .rot_vld  (r2_vld),
    .rot_a    (r2_y),
    .rot_b    (r2_z),
    .rot_pass (r2_x)
  );

  prt_plane_rot u_rot_xy (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (r2_vld),
    .a        (r2_x),
    .b        (r2_y),
    .pass     (r2_z),
    .sin_v    (coef_r[4]),
    .cos_v    (coef_r[5]),
    .rot_vld  (r3_vld),
    .rot_a    (r3_x),
    .rot_b    (r3_y),
    .rot_pass (r3_z)
  );

  // last stage registers drive the result ports directly
  assign out_valid      = r3_vld;
  assign out_data.out_x = r3_x;
  assign out_data.out_y = r3_y;
  assign out_data.out_z = r3_z;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // every strobe comes from an earlier start transfer taken while not busy
  a_out_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 6))
    else $error("result strobe without matching start transfer");

  // an angle write blocks new points until the coefficients are refreshed
  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    reg_wr |=> busy)
    else $error("angle write did not start a coefficient fetch");

  // the fetch only ends on the cycle the last rom word is stored
  a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> $past(rom_vld_r))
    else $error("coefficient fetch ended before last word was stored");

endmodule
